// File: src/assert_macros.svh
// Assertion macros used by the checker of the instruction list executor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ILE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ile_pkg.sv
// Package of the instruction list executor: sizes, codes, types and the ALU function
package ile_pkg;

    localparam int WORD_BITS   = 16;
    localparam int STACK_DEPTH = 8;
    localparam int OP_W        = 8;
    localparam int MOD_W       = 8;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    // Opcodes
    localparam logic [OP_W-1:0] OP_END  = 8'd0;
    localparam logic [OP_W-1:0] OP_POP  = 8'd1;
    localparam logic [OP_W-1:0] OP_RET  = 8'd2;
    localparam logic [OP_W-1:0] OP_JMP  = 8'd3;
    localparam logic [OP_W-1:0] OP_CAL  = 8'd4;
    localparam logic [OP_W-1:0] OP_S    = 8'd5;
    localparam logic [OP_W-1:0] OP_R    = 8'd6;
    localparam logic [OP_W-1:0] OP_AND  = 8'd7;
    localparam logic [OP_W-1:0] OP_OR   = 8'd8;
    localparam logic [OP_W-1:0] OP_XOR  = 8'd9;
    localparam logic [OP_W-1:0] OP_ANDN = 8'd10;
    localparam logic [OP_W-1:0] OP_ORN  = 8'd11;
    localparam logic [OP_W-1:0] OP_XORN = 8'd12;
    localparam logic [OP_W-1:0] OP_LD   = 8'd13;
    localparam logic [OP_W-1:0] OP_ST   = 8'd14;
    localparam logic [OP_W-1:0] OP_LDN  = 8'd15;
    localparam logic [OP_W-1:0] OP_STN  = 8'd16;
    localparam logic [OP_W-1:0] OP_ADD  = 8'd17;
    localparam logic [OP_W-1:0] OP_SUB  = 8'd18;
    localparam logic [OP_W-1:0] OP_MUL  = 8'd19;
    localparam logic [OP_W-1:0] OP_DIV  = 8'd20;
    localparam logic [OP_W-1:0] OP_GT   = 8'd21;
    localparam logic [OP_W-1:0] OP_GE   = 8'd22;
    localparam logic [OP_W-1:0] OP_EQ   = 8'd23;
    localparam logic [OP_W-1:0] OP_NE   = 8'd24;
    localparam logic [OP_W-1:0] OP_LT   = 8'd25;
    localparam logic [OP_W-1:0] OP_LE   = 8'd26;

    // Modifiers
    localparam logic [MOD_W-1:0] MOD_NEGATE = 8'd1;
    localparam logic [MOD_W-1:0] MOD_PUSH   = 8'd2;

    typedef logic [WORD_BITS-1:0] ile_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MULDIV
    } ile_state_t;

    // One stack entry: pending opcode and the left operand saved with it
    typedef struct packed {
        logic [OP_W-1:0] opcode;
        ile_word_t       value;
    } ile_entry_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } ile_md_ctrl_t;

    typedef struct packed {
        logic      done;
        ile_word_t result;
    } ile_md_stat_t;

    function automatic logic ile_is_operation(input logic [OP_W-1:0] op);
        return (op >= OP_AND && op <= OP_XORN) || (op >= OP_ADD && op <= OP_LE);
    endfunction

    function automatic logic ile_is_muldiv(input logic [OP_W-1:0] op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

    // Combinational operations; MUL and DIV go through the serial unit
    function automatic ile_word_t ile_alu(input logic [OP_W-1:0] op,
                                          input ile_word_t a, input ile_word_t b);
        ile_word_t r;
        r = '0;
        case (op)
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_ANDN: r = a & ~b;
            OP_ORN:  r = a | ~b;
            OP_XORN: r = a ^ ~b;
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_GT:   r = ile_word_t'(a > b);
            OP_GE:   r = ile_word_t'(a >= b);
            OP_EQ:   r = ile_word_t'(a == b);
            OP_NE:   r = ile_word_t'(a != b);
            OP_LT:   r = ile_word_t'(a < b);
            OP_LE:   r = ile_word_t'(a <= b);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: src/ile_stack_ram.sv
// Stack memory of the instruction list executor: pending opcode and value per level
module ile_stack_ram
    import ile_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  ile_entry_t       wr_data,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr,
    output ile_entry_t       rd_data
);

    ile_entry_t mem [STACK_DEPTH];
    ile_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/ile_muldiv.sv
// Serial multiply and restoring divide unit, one bit per cycle
module ile_muldiv
    import ile_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ile_md_ctrl_t ctrl,
    input  ile_word_t    a,
    input  ile_word_t    b,
    output ile_md_stat_t stat
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg, div_next;
    ile_word_t        x_reg, x_next;
    ile_word_t        y_reg, y_next;
    ile_word_t        r_reg, r_next;

    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS+1:0] diff;
    logic                 q_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        r_reg   <= r_next;
    end

    // Divide step: a zero divisor always subtracts, giving an all-ones quotient
    assign shifted = {r_reg, x_reg[WORD_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, y_reg};
    assign q_bit   = !diff[WORD_BITS+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            div_next  = ctrl.is_div;
            x_next    = a;
            y_next    = b;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                r_next = q_bit ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
                x_next = {x_reg[WORD_BITS-2:0], q_bit};
            end
            else
            begin
                if (y_reg[0])
                begin
                    r_next = r_reg + x_reg;
                end
                x_next = {x_reg[WORD_BITS-2:0], 1'b0};
                y_next = {1'b0, y_reg[WORD_BITS-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign stat.done   = done_reg;
    assign stat.result = div_reg ? x_reg : r_reg;

endmodule

// File: src/plc_instruction_list_executor.sv
// Top level of the instruction list executor: decode, accumulator, stack control
//
// Executes one instruction list instruction per request. An input request
// carries opcode, modifier, operand location and the operand value already
// fetched; it is taken at a clock edge with in_valid high and in_stall low.
// Each instruction yields exactly one output request (store fields,
// accumulator, scan_done, illegal), taken with out_valid high and out_stall low.
// The request is held in the EXEC state and committed to the output register
// once the slot is free; MUL and DIV (also when applied at a close paren)
// first run the 16 steps of the shared serial multiply/divide unit.
// A new request is not taken until the current instruction has completed.
// The stack memory is read in the cycle the request is taken and written when
// the instruction completes, so one instruction is in flight at a time.
// While out_stall holds the output register, the block still takes the next
// request and works on it; it completes that one once the slot frees.
// Reset clears the accumulator, the stack level and all handshake state; the
// stack memory is not cleared, as only levels below the stack level are used.
module plc_instruction_list_executor
    import ile_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      opcode,
    input  logic [MOD_W-1:0]     modifier,
    input  logic [7:0]           operand_area,
    input  logic [7:0]           operand_byte,
    input  logic [7:0]           operand_bit,
    input  logic [WORD_BITS-1:0] operand_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 store_enable,
    output logic [7:0]           store_area,
    output logic [7:0]           store_byte,
    output logic [7:0]           store_bit,
    output logic [WORD_BITS-1:0] store_value,
    output logic [WORD_BITS-1:0] accumulator,
    output logic                 scan_done,
    output logic                 illegal
);

    ile_state_t       state_reg, state_next;
    ile_word_t        acc_reg, acc_next;
    logic [LVL_W-1:0] level_reg, level_next;

    // Held instruction
    logic [OP_W-1:0]  op_reg;
    logic [MOD_W-1:0] mod_reg;
    logic [7:0]       area_reg, byte_reg, bit_reg;
    ile_word_t        val_reg;

    // Output register
    logic      out_valid_reg, out_valid_next;
    logic      st_en_reg;
    logic [7:0] st_area_reg, st_byte_reg, st_bit_reg;
    ile_word_t st_val_reg;
    ile_word_t acc_out_reg;
    logic      done_reg;
    logic      bad_reg;

    logic in_accept;
    logic slot_free;
    logic commit;

    logic [LVL_W-1:0] level_dec;
    ile_entry_t       rd_data;
    ile_entry_t       wr_data;
    logic             ram_we;

    logic         is_pop, is_oper, is_push;
    logic [OP_W-1:0] exe_op;
    ile_word_t    exe_a, exe_b, op_value;
    logic         needs_md;
    ile_md_ctrl_t md_ctrl;
    ile_md_stat_t md_stat;

    ile_word_t        res_acc;
    logic [LVL_W-1:0] res_level;
    logic             res_st_en, res_done, res_bad;
    ile_word_t        res_st_val;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign level_dec = level_reg - 1'b1;

    ile_stack_ram u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (level_reg[PTR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (in_accept),
        .rd_addr (level_dec[PTR_W-1:0]),
        .rd_data (rd_data)
    );

    ile_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (md_ctrl),
        .a     (exe_a),
        .b     (exe_b),
        .stat  (md_stat)
    );

    // Operand selection: a close paren applies the popped opcode to the
    // popped value and the accumulator; otherwise accumulator op operand.
    assign is_pop  = (op_reg == OP_POP);
    assign is_oper = ile_is_operation(op_reg);
    assign is_push = is_oper && (mod_reg == MOD_PUSH);
    assign exe_op  = is_pop ? rd_data.opcode : op_reg;
    assign exe_a   = is_pop ? rd_data.value : acc_reg;
    assign exe_b   = is_pop ? acc_reg : ((mod_reg == MOD_NEGATE) ? ~val_reg : val_reg);
    assign needs_md = ile_is_muldiv(exe_op) &&
                      ((is_pop && level_reg != '0) || (is_oper && !is_push));
    assign op_value = (state_reg == ST_MULDIV) ? md_stat.result : ile_alu(exe_op, exe_a, exe_b);

    assign wr_data.opcode = op_reg;
    assign wr_data.value  = acc_reg;

    // Instruction effect, applied on commit
    always_comb
    begin
        res_acc    = acc_reg;
        res_level  = level_reg;
        res_st_en  = 1'b0;
        res_st_val = '0;
        res_done   = 1'b0;
        res_bad    = 1'b0;
        case (op_reg)
            OP_END:
            begin
                res_done  = 1'b1;
                res_acc   = '0;
                res_level = '0;
            end
            OP_RET, OP_JMP, OP_CAL:
            begin
                res_acc = acc_reg;
            end
            OP_S:
            begin
                if (acc_reg == ile_word_t'(1))
                begin
                    res_st_en  = 1'b1;
                    res_st_val = ile_word_t'(1);
                end
            end
            OP_R:
            begin
                if (acc_reg == ile_word_t'(1))
                begin
                    res_st_en = 1'b1;
                end
            end
            OP_LD:  res_acc = val_reg;
            OP_LDN: res_acc = ~val_reg;
            OP_ST:
            begin
                res_st_en  = 1'b1;
                res_st_val = acc_reg;
            end
            OP_STN:
            begin
                res_st_en  = 1'b1;
                res_st_val = ~acc_reg;
            end
            OP_POP:
            begin
                if (level_reg == '0)
                begin
                    res_bad = 1'b1;
                end
                else
                begin
                    res_level = level_dec;
                    res_acc   = op_value;
                end
            end
            default:
            begin
                if (!is_oper)
                begin
                    res_bad = 1'b1;
                end
                else if (is_push)
                begin
                    if (level_reg == LVL_W'(STACK_DEPTH))
                    begin
                        res_bad = 1'b1;
                    end
                    else
                    begin
                        res_level = level_reg + 1'b1;
                        res_acc   = val_reg;
                    end
                end
                else
                begin
                    res_acc = op_value;
                end
            end
        endcase
    end

    // Sequencer: take a request, then commit it or run the serial unit first
    always_comb
    begin
        state_next     = state_reg;
        commit         = 1'b0;
        md_ctrl.start  = 1'b0;
        md_ctrl.is_div = (exe_op == OP_DIV);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (needs_md)
                begin
                    md_ctrl.start = 1'b1;
                    state_next    = ST_MULDIV;
                end
                else if (slot_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MULDIV:
            begin
                if (md_stat.done && slot_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_we         = commit && is_push && (res_level != level_reg);
    assign acc_next       = commit ? res_acc : acc_reg;
    assign level_next     = commit ? res_level : level_reg;
    assign out_valid_next = commit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Latch the instruction on accept
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= opcode;
            mod_reg  <= modifier;
            area_reg <= operand_area;
            byte_reg <= operand_byte;
            bit_reg  <= operand_bit;
            val_reg  <= operand_value;
        end
    end

    // Load the output register on commit; zero the location when no store
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            st_en_reg   <= res_st_en;
            st_area_reg <= res_st_en ? area_reg : 8'd0;
            st_byte_reg <= res_st_en ? byte_reg : 8'd0;
            st_bit_reg  <= res_st_en ? bit_reg : 8'd0;
            st_val_reg  <= res_st_en ? res_st_val : '0;
            acc_out_reg <= res_acc;
            done_reg    <= res_done;
            bad_reg     <= res_bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign store_enable = st_en_reg;
    assign store_area   = st_area_reg;
    assign store_byte   = st_byte_reg;
    assign store_bit    = st_bit_reg;
    assign store_value  = st_val_reg;
    assign accumulator  = acc_out_reg;
    assign scan_done    = done_reg;
    assign illegal      = bad_reg;

endmodule

// File: src/ile_checker.sv
// Port-level checker of the instruction list executor and its bind
`include "assert_macros.svh"

module ile_checker
    import ile_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 store_enable,
    input logic [7:0]           store_area,
    input logic [7:0]           store_byte,
    input logic [7:0]           store_bit,
    input logic [WORD_BITS-1:0] store_value,
    input logic [WORD_BITS-1:0] accumulator,
    input logic                 scan_done
);

    `ILE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `ILE_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second request taken while busy")
    `ILE_ASSERT_SAME(a_no_store_zero, out_valid && !store_enable, store_area == 8'd0 && store_byte == 8'd0 && store_bit == 8'd0 && store_value == '0, "store fields set without store")
    `ILE_ASSERT_SAME(a_end_clears, out_valid && scan_done, accumulator == '0 && !store_enable, "end of scan left state")

endmodule

bind plc_instruction_list_executor ile_checker u_ile_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench of plc_instruction_list_executor: directed corners and random IL programs
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    // Modifier codes the package leaves unnamed
    localparam logic [MOD_W-1:0] MOD_NONE   = 8'd0;
    localparam logic [MOD_W-1:0] MOD_NORMAL = 8'd3;
    localparam logic [MOD_W-1:0] MOD_COND   = 8'd4;

    // Quiet cycles (no request taken on either side) before the run is abandoned.
    // Slowest legal stretch is the output hold below plus a MUL/DIV, so this is
    // several times over.
    localparam int WATCHDOG_CYCLES = 2000;
    // Length of the long output hold that backs the block up into its input
    localparam int HOLD_CYCLES     = 300;
    // Cycles to wait after the last result has been checked
    localparam int DRAIN_CYCLES    = 40;

    // One instruction request as offered to the block
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [MOD_W-1:0] mod;
        logic [7:0]       area;
        logic [7:0]       loc_byte;
        logic [7:0]       loc_bit;
        ile_word_t        val;
    } instr_t;

    // One result request as the block should present it
    typedef struct {
        logic      st_en;
        logic [7:0] st_area;
        logic [7:0] st_byte;
        logic [7:0] st_bit;
        ile_word_t st_val;
        ile_word_t acc;
        logic      done;
        logic      bad;
    } exec_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic [OP_W-1:0]      opcode        = '0;
    logic [MOD_W-1:0]     modifier      = '0;
    logic [7:0]           operand_area  = '0;
    logic [7:0]           operand_byte  = '0;
    logic [7:0]           operand_bit   = '0;
    logic [WORD_BITS-1:0] operand_value = '0;
    logic                 out_stall     = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    logic                 store_enable;
    logic [7:0]           store_area;
    logic [7:0]           store_byte;
    logic [7:0]           store_bit;
    logic [WORD_BITS-1:0] store_value;
    logic [WORD_BITS-1:0] accumulator;
    logic                 scan_done;
    logic                 illegal;

    plc_instruction_list_executor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .modifier      (modifier),
        .operand_area  (operand_area),
        .operand_byte  (operand_byte),
        .operand_bit   (operand_bit),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .store_enable  (store_enable),
        .store_area    (store_area),
        .store_byte    (store_byte),
        .store_bit     (store_bit),
        .store_value   (store_value),
        .accumulator   (accumulator),
        .scan_done     (scan_done),
        .illegal       (illegal)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Predictor state: accumulator and the paren stack as the block should
    // hold them after every request taken so far.
    // ------------------------------------------------------------------
    ile_word_t       predicted_acc;
    ile_word_t       paren_vals [STACK_DEPTH];
    logic [OP_W-1:0] paren_ops  [STACK_DEPTH];
    int              paren_depth;

    // Results owed by the block, oldest first
    exec_result_t    pending_results[$];
    exec_result_t    oldest_result;

    int error_count  = 0;
    int issued_count = 0;
    int quiet_cycles = 0;
    int gap_pct      = 0;   // chance per cycle that the sender idles
    int stall_pct    = 0;   // chance per cycle that the receiver stalls
    int hold_ticket  = 0;   // bumped by a test to ask for a long output hold
    int hold_seen    = 0;
    int hold_left    = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Binary operations of the accumulator; false for anything that is not one
    function automatic logic eval_op(input logic [OP_W-1:0] op, input ile_word_t a,
                                     input ile_word_t b, output ile_word_t r);
        r = '0;
        case (op)
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_ANDN: r = a & ~b;
            OP_ORN:  r = a | ~b;
            OP_XORN: r = a ^ ~b;
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            OP_DIV:  r = (b == '0) ? '1 : a / b;
            OP_GT:   r = (a > b)  ? ile_word_t'(1) : '0;
            OP_GE:   r = (a >= b) ? ile_word_t'(1) : '0;
            OP_EQ:   r = (a == b) ? ile_word_t'(1) : '0;
            OP_NE:   r = (a != b) ? ile_word_t'(1) : '0;
            OP_LT:   r = (a < b)  ? ile_word_t'(1) : '0;
            OP_LE:   r = (a <= b) ? ile_word_t'(1) : '0;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Execute one instruction on the predictor state and return the result it owes
    function automatic exec_result_t execute_instr(input instr_t ins);
        exec_result_t res;
        ile_word_t    operand;
        ile_word_t    combined;
        logic         known;
        res = '{default: '0};
        case (ins.op)
            OP_END:
            begin
                res.done      = 1'b1;
                predicted_acc = '0;
                paren_depth   = 0;
            end
            OP_RET, OP_JMP, OP_CAL: ;
            OP_S:
            begin
                if (predicted_acc == ile_word_t'(1))
                begin
                    res.st_en  = 1'b1;
                    res.st_val = ile_word_t'(1);
                end
            end
            OP_R:
            begin
                if (predicted_acc == ile_word_t'(1))
                begin
                    res.st_en  = 1'b1;
                    res.st_val = '0;
                end
            end
            OP_LD:  predicted_acc = ins.val;
            OP_LDN: predicted_acc = ~ins.val;
            OP_ST:
            begin
                res.st_en  = 1'b1;
                res.st_val = predicted_acc;
            end
            OP_STN:
            begin
                res.st_en  = 1'b1;
                res.st_val = ~predicted_acc;
            end
            OP_POP:
            begin
                // close paren: saved value is the left operand, accumulator the right
                if (paren_depth == 0)
                    res.bad = 1'b1;
                else
                begin
                    paren_depth--;
                    if (eval_op(paren_ops[paren_depth], paren_vals[paren_depth],
                                predicted_acc, combined))
                        predicted_acc = combined;
                    else
                        res.bad = 1'b1;
                end
            end
            default:
            begin
                known = ins.op inside {[OP_AND:OP_XORN], [OP_ADD:OP_LE]};
                if (!known)
                    res.bad = 1'b1;
                else if (ins.mod == MOD_PUSH)
                begin
                    if (paren_depth >= STACK_DEPTH)
                        res.bad = 1'b1;
                    else
                    begin
                        paren_vals[paren_depth] = predicted_acc;
                        paren_ops[paren_depth]  = ins.op;
                        paren_depth++;
                        predicted_acc = ins.val;
                    end
                end
                else
                begin
                    operand = (ins.mod == MOD_NEGATE) ? ~ins.val : ins.val;
                    if (eval_op(ins.op, predicted_acc, operand, combined))
                        predicted_acc = combined;
                end
            end
        endcase
        if (res.st_en)
        begin
            res.st_area = ins.area;
            res.st_byte = ins.loc_byte;
            res.st_bit  = ins.loc_bit;
        end
        res.acc = predicted_acc;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one instruction request and hold it until it is taken.
    // Random idle cycles go in front of it; valid never looks at in_stall.
    // Called right after a rising edge, so every drive lands as one NBA.
    // ------------------------------------------------------------------
    task automatic issue_instr(input logic [OP_W-1:0] op, input logic [MOD_W-1:0] mod,
                               input logic [7:0] area, input logic [7:0] loc_byte,
                               input logic [7:0] loc_bit, input ile_word_t val);
        instr_t ins;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        modifier      <= mod;
        operand_area  <= area;
        operand_byte  <= loc_byte;
        operand_bit   <= loc_bit;
        operand_value <= val;
        // sample in_stall as it stood at the edge: the block's NBAs are not applied yet
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ins = '{op, mod, area, loc_byte, loc_bit, val};
        pending_results.push_back(execute_instr(ins));
        issued_count++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold whenever a test bumps the ticket.
    // The hold is counted here so that the sender keeps offering meanwhile.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_ticket != hold_seen)
        begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checker and watchdog. Every result request is matched against the
    // oldest outstanding prediction, field by field.
    // ------------------------------------------------------------------
    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: result with nothing outstanding, expected none, got acc %h",
                             $time, accumulator);
                end
                else
                begin
                    oldest_result = pending_results.pop_front();
                    compare_field("store_enable", 16'(oldest_result.st_en),   16'(store_enable));
                    compare_field("store_area",   16'(oldest_result.st_area), 16'(store_area));
                    compare_field("store_byte",   16'(oldest_result.st_byte), 16'(store_byte));
                    compare_field("store_bit",    16'(oldest_result.st_bit),  16'(store_bit));
                    compare_field("store_value",  16'(oldest_result.st_val),  16'(store_value));
                    compare_field("accumulator",  16'(oldest_result.acc),     16'(accumulator));
                    compare_field("scan_done",    16'(oldest_result.done),    16'(scan_done));
                    compare_field("illegal",      16'(oldest_result.bad),     16'(illegal));
                end
            end
            // count cycles in which neither side moves a request
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Random program generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_loc();
        return 8'($urandom_range(255));
    endfunction

    // Operand values skewed towards the interesting ones: equal to the
    // accumulator (EQ/NE/GE), zero (DIV by zero), one (S/R) and the extremes
    function automatic ile_word_t pick_operand();
        case ($urandom_range(7))
            0, 1, 2: return ile_word_t'($urandom_range(16'hFFFF));
            3:       return ile_word_t'($urandom_range(3));
            4:       return predicted_acc;
            5:       return '0;
            6:       return '1;
            default: return ile_word_t'(1);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_binop();
        if ($urandom_range(1) == 0)
            return OP_W'($urandom_range(OP_AND, OP_XORN));
        return OP_W'($urandom_range(OP_ADD, OP_LE));
    endfunction

    // Modifier for a plain operation; any code but push and negate is treated as normal
    function automatic logic [MOD_W-1:0] pick_plain_mod();
        case ($urandom_range(9))
            0, 1, 2: return MOD_NORMAL;
            3, 4:    return MOD_NONE;
            5, 6:    return MOD_NEGATE;
            7:       return MOD_COND;
            default: return MOD_W'($urandom_range(255));
        endcase
    endfunction

    task automatic emit_pop();
        issue_instr(OP_POP, MOD_W'($urandom_range(255)), rand_loc(), rand_loc(), rand_loc(),
                    pick_operand());
    endtask

    task automatic emit_push();
        issue_instr(pick_binop(), MOD_PUSH, rand_loc(), rand_loc(), rand_loc(), pick_operand());
    endtask

    // One well-formed IL program with random content: load, a body of operations,
    // parens, stores, loads and jumps, close most parens, maybe store, maybe END.
    // A small share of the body is noise (any opcode, any modifier).
    task automatic emit_program();
        int              steps;
        int              roll;
        logic [OP_W-1:0] op;
        issue_instr(($urandom_range(1) == 0) ? OP_LD : OP_LDN, MOD_W'($urandom_range(255)),
                    rand_loc(), rand_loc(), rand_loc(), pick_operand());
        // now and then nest past the stack depth, then unwind past empty
        if ($urandom_range(7) == 0)
        begin
            repeat (STACK_DEPTH + 1)
                emit_push();
            repeat (STACK_DEPTH + 2)
                emit_pop();
        end
        steps = $urandom_range(2, 12);
        repeat (steps)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
                issue_instr(pick_binop(), pick_plain_mod(), rand_loc(), rand_loc(), rand_loc(),
                            pick_operand());
            else if (roll < 60)
                emit_push();
            else if (roll < 72 && paren_depth > 0)
                emit_pop();
            else if (roll < 85)
            begin
                case ($urandom_range(3))
                    0:       op = OP_ST;
                    1:       op = OP_STN;
                    2:       op = OP_S;
                    default: op = OP_R;
                endcase
                issue_instr(op, MOD_W'($urandom_range(255)), rand_loc(), rand_loc(), rand_loc(),
                            pick_operand());
            end
            else if (roll < 92)
                issue_instr(($urandom_range(1) == 0) ? OP_LD : OP_LDN, pick_plain_mod(),
                            rand_loc(), rand_loc(), rand_loc(), pick_operand());
            else if (roll < 95)
            begin
                case ($urandom_range(2))
                    0:       op = OP_RET;
                    1:       op = OP_JMP;
                    default: op = OP_CAL;
                endcase
                issue_instr(op, MOD_W'($urandom_range(255)), rand_loc(), rand_loc(), rand_loc(),
                            pick_operand());
            end
            else
                issue_instr(OP_W'($urandom_range(255)), MOD_W'($urandom_range(255)), rand_loc(),
                            rand_loc(), rand_loc(), ile_word_t'($urandom_range(16'hFFFF)));
        end
        // close most of what is still open
        while (paren_depth > 0 && $urandom_range(3) != 0)
            emit_pop();
        if ($urandom_range(2) == 0)
            issue_instr(OP_ST, MOD_W'($urandom_range(255)), rand_loc(), rand_loc(), rand_loc(),
                        pick_operand());
        if ($urandom_range(3) == 0)
            issue_instr(OP_END, MOD_W'($urandom_range(255)), rand_loc(), rand_loc(), rand_loc(),
                        pick_operand());
    endtask

    task automatic run_programs(input int count);
        int target;
        target = issued_count + count;
        while (issued_count < target)
            emit_program();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every opcode at least once, field extremes, stores, parens, underflow and unknown codes
    task automatic test_directed();
        gap_pct    = 0;
        stall_pct <= 0;
        // modifier is ignored on LD, even push
        issue_instr(OP_LD,   MOD_PUSH,   8'h00, 8'h00, 8'h00, 16'hFFFF);
        issue_instr(OP_ST,   8'hFF,      8'hFF, 8'hFF, 8'hFF, 16'h0000);
        issue_instr(OP_STN,  MOD_NONE,   8'hA5, 8'h5A, 8'h07, 16'h1234);
        // LDN only loads; leaves one in the accumulator for S and R
        issue_instr(OP_LDN,  MOD_NEGATE, 8'h11, 8'h22, 8'h33, 16'hFFFE);
        issue_instr(OP_S,    MOD_NORMAL, 8'h01, 8'h02, 8'h03, 16'h0000);
        issue_instr(OP_R,    MOD_COND,   8'hFE, 8'hFD, 8'hFC, 16'hFFFF);
        // close paren with nothing open
        issue_instr(OP_POP,  MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'h0000);
        // nested parens: 1 + (FFFF * (FFFF / 0))
        issue_instr(OP_ADD,  MOD_PUSH,   8'h00, 8'h00, 8'h00, 16'hFFFF);
        issue_instr(OP_MUL,  MOD_PUSH,   8'h00, 8'h00, 8'h00, 16'hFFFF);
        issue_instr(OP_DIV,  MOD_COND,   8'h00, 8'h00, 8'h00, 16'h0000);
        issue_instr(OP_POP,  MOD_PUSH,   8'h00, 8'h00, 8'h00, 16'h0000);
        issue_instr(OP_POP,  MOD_NONE,   8'h00, 8'h00, 8'h00, 16'h0000);
        // accumulator is not one here, so no store
        issue_instr(OP_S,    MOD_NORMAL, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        issue_instr(OP_SUB,  MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'h0003);
        issue_instr(OP_AND,  MOD_NEGATE, 8'h00, 8'h00, 8'h00, 16'h00FF);
        issue_instr(OP_OR,   MOD_NONE,   8'h00, 8'h00, 8'h00, 16'h0F0F);
        issue_instr(OP_XOR,  MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'hFFFF);
        issue_instr(OP_ANDN, MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'h00F0);
        issue_instr(OP_ORN,  MOD_COND,   8'h00, 8'h00, 8'h00, 16'hFFF0);
        issue_instr(OP_XORN, 8'h80,      8'h00, 8'h00, 8'h00, 16'h1234);
        issue_instr(OP_GT,   MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'h0000);
        issue_instr(OP_GE,   MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'h0001);
        issue_instr(OP_EQ,   MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'h0001);
        issue_instr(OP_NE,   MOD_NEGATE, 8'h00, 8'h00, 8'h00, 16'hFFFE);
        issue_instr(OP_LT,   MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'hFFFF);
        issue_instr(OP_LE,   MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'h0000);
        // unknown codes, with and without push
        issue_instr(8'd27,   MOD_PUSH,   8'h00, 8'h00, 8'h00, 16'hFFFF);
        issue_instr(8'd255,  MOD_NONE,   8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        issue_instr(OP_RET,  MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'h0000);
        issue_instr(OP_JMP,  MOD_NORMAL, 8'h00, 8'h00, 8'h00, 16'h0000);
        issue_instr(OP_CAL,  MOD_PUSH,   8'h00, 8'h00, 8'h00, 16'h0000);
        issue_instr(OP_END,  8'hFF,      8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    endtask

    task automatic test_back_to_back();
        gap_pct    = 0;
        stall_pct <= 0;
        run_programs(450);
    endtask

    task automatic test_sender_gaps();
        gap_pct    = 52;
        stall_pct <= 0;
        run_programs(450);
    endtask

    task automatic test_receiver_stalls();
        gap_pct    = 0;
        stall_pct <= 52;
        run_programs(450);
    endtask

    task automatic test_both_idle();
        gap_pct    = 22;
        stall_pct <= 22;
        run_programs(400);
    endtask

    // Hold the output for a long stretch while requests keep coming, so the
    // block fills up and pushes back on its input
    task automatic test_output_hold();
        gap_pct      = 0;
        stall_pct   <= 0;
        hold_ticket <= hold_ticket + 1;
        run_programs(80);
    endtask

    initial
    begin
        paren_depth   = 0;
        predicted_acc = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_output_hold();

        // drop valid and let the last results drain; the watchdog covers a hang
        in_valid  <= 1'b0;
        stall_pct <= 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
